// ----- hdl/interrupt_vector_bitmap_allocator_top_macros.svh -----
// Assertion macros shared by the allocator checker.
`ifndef INTERRUPT_VECTOR_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define INTERRUPT_VECTOR_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Checked while out of reset.
`define IVBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define IVBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/ivba_pkg.sv -----
// Package: sizes, codes and controller/datapath interface types of the allocator.
package ivba_pkg;

    localparam int MAP_BYTES      = 32;
    localparam int RESERVED_BYTES = 4;
    localparam int VECTOR_BYTES   = 32;

    localparam int SCAN_BYTES  = (MAP_BYTES < VECTOR_BYTES) ? MAP_BYTES : VECTOR_BYTES;
    localparam int RES_BYTES   = (RESERVED_BYTES < MAP_BYTES) ? RESERVED_BYTES : MAP_BYTES;
    localparam int IDX_W       = $clog2(SCAN_BYTES);
    localparam int RSV_VECTORS = RESERVED_BYTES * 8;

    localparam logic       SCAN_EMPTY  = (RES_BYTES >= SCAN_BYTES);
    localparam logic [7:0] FULL_BYTE   = 8'hFF;
    localparam logic [7:0] EMPTY_BYTE  = 8'h00;
    localparam logic [7:0] NONE_VECTOR = 8'hFF;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NONE      = 2'd1,
        ST_FREED     = 2'd2,
        ST_REJECTED  = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic free;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic alloc_hit;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/ivba_ctrl.sv -----
// Controller state machine of the allocator.
module ivba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    input  ivba_pkg::t_stat i_stat,
    output ivba_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    ivba_pkg::t_state r_state;
    ivba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ivba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ivba_pkg::S_IDLE) || !i_rst_n;
        case (r_state)
            ivba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_op == ivba_pkg::OP_FREE) begin
                        n_state = ivba_pkg::S_FREE;
                    end else if (ivba_pkg::SCAN_EMPTY) begin
                        n_state = ivba_pkg::S_DONE;
                    end else begin
                        n_state = ivba_pkg::S_SCAN;
                    end
                end
            end
            ivba_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.alloc_hit || i_stat.scan_last) begin
                    n_state = ivba_pkg::S_DONE;
                end
            end
            ivba_pkg::S_FREE: begin
                o_cmd.free = 1'b1;
                n_state    = ivba_pkg::S_DONE;
            end
            ivba_pkg::S_DONE: begin
                // hold the result until the output register can take it
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ivba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ivba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/ivba_datapath.sv -----
// Datapath: bitmap registers, byte scan, free update and output register.
module ivba_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_vector_in,
    input  ivba_pkg::t_cmd  i_cmd,
    input  logic            i_out_stall,
    output ivba_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output logic [7:0]      o_vector_out,
    output logic [1:0]      o_status
);

    logic [7:0]                  r_map [ivba_pkg::SCAN_BYTES];
    logic [7:0]                  r_vec;
    logic [ivba_pkg::IDX_W-1:0]  r_idx;
    logic [7:0]                  r_res_vec;
    ivba_pkg::t_status           r_res_status;
    logic                        r_out_valid;
    logic [7:0]                  r_out_vec;
    ivba_pkg::t_status           r_out_status;

    logic [7:0]                  w_byte;
    logic [2:0]                  w_bit;
    logic                        w_hit;
    logic                        w_rsv;
    logic                        w_in_map;
    logic [ivba_pkg::IDX_W-1:0]  w_fidx;

    assign w_byte   = r_map[r_idx];
    assign w_hit    = (w_byte != ivba_pkg::FULL_BYTE);
    assign w_rsv    = (r_vec < 8'(ivba_pkg::RSV_VECTORS));
    assign w_in_map = ({1'b0, r_vec[7:3]} < 6'(ivba_pkg::SCAN_BYTES));
    assign w_fidx   = r_vec[ivba_pkg::IDX_W+2:3];

    // lowest clear bit: walk downward so the lowest one wins
    always_comb begin
        w_bit = '0;
        for (int k = 7; k >= 0; k--) begin
            if (!w_byte[k]) begin
                w_bit = 3'(k);
            end
        end
    end

    always_comb begin
        o_stat.alloc_hit = w_hit;
        o_stat.scan_last = (r_idx == ivba_pkg::IDX_W'(ivba_pkg::SCAN_BYTES - 1));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ivba_pkg::SCAN_BYTES; i++) begin
                r_map[i] <= (i < ivba_pkg::RES_BYTES) ? ivba_pkg::FULL_BYTE
                                                      : ivba_pkg::EMPTY_BYTE;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan && w_hit) begin
                r_map[r_idx] <= w_byte | (8'(1) << w_bit);
            end
            if (i_cmd.free && !w_rsv && w_in_map) begin
                r_map[w_fidx] <= r_map[w_fidx] & ~(8'(1) << r_vec[2:0]);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vec        <= i_vector_in;
            r_idx        <= ivba_pkg::IDX_W'(ivba_pkg::RES_BYTES);
            r_res_vec    <= ivba_pkg::NONE_VECTOR;
            r_res_status <= ivba_pkg::ST_NONE;
        end
        if (i_cmd.scan) begin
            if (w_hit) begin
                r_res_vec    <= 8'({r_idx, w_bit});
                r_res_status <= ivba_pkg::ST_ALLOCATED;
            end else begin
                r_idx <= r_idx + ivba_pkg::IDX_W'(1);
            end
        end
        if (i_cmd.free) begin
            r_res_vec    <= '0;
            r_res_status <= w_rsv ? ivba_pkg::ST_REJECTED : ivba_pkg::ST_FREED;
        end
        if (i_cmd.out_load) begin
            r_out_vec    <= r_res_vec;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_vector_out = r_out_vec;
    assign o_status     = r_out_status;

endmodule

// ----- hdl/interrupt_vector_bitmap_allocator_top.sv -----
// Top level of the interrupt vector bitmap allocator.
//
// Keeps a used/free bitmap of 256 interrupt vectors, one bit each, in 32
// byte registers. Vectors 0-31 are reserved out of reset, the rest free.
// Input channel (i_in_valid / o_in_stall): i_op 0 allocates the lowest
// free vector at or above the reserved area, i_op 1 frees i_vector_in.
// Output channel (o_out_valid / i_out_stall): one result per transaction,
// o_vector_out plus o_status (allocated, none available, freed, rejected).
// A free passes from S_FREE to S_DONE; an allocation walks the map one
// byte per cycle from the first unreserved byte until a byte with a clear
// bit is found or the last byte has been scanned, then moves to S_DONE.
// The byte scan is the throughput limit: one transaction in flight, a new
// one taken the cycle after its result is registered.
// A result waiting in the output register does not block the next accept;
// only the following result waits on i_out_stall, which then holds
// o_out_valid and the payload steady.
// Synchronous reset (i_rst_n low) restores the reserved pattern, drops
// o_out_valid and stalls the input.
module interrupt_vector_bitmap_allocator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_vector_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_vector_out,
    output logic [1:0] o_status
);

    ivba_pkg::t_cmd  w_cmd;
    ivba_pkg::t_stat w_stat;

    ivba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ivba_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vector_in  (i_vector_in),
        .i_cmd        (w_cmd),
        .i_out_stall  (i_out_stall),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_vector_out (o_vector_out),
        .o_status     (o_status)
    );

endmodule

// ----- hdl/ivba_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
`include "interrupt_vector_bitmap_allocator_top_macros.svh"

module ivba_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_op,
    input logic [7:0] i_vector_in,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_vector_out,
    input logic [1:0] o_status
);

    `IVBA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_vector_out) && $stable(o_status), "stalled result changed")
    `IVBA_ASSERT(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall, "second transaction taken while busy")
    `IVBA_ASSERT(a_free_vec_zero, o_out_valid && (o_status == ivba_pkg::ST_FREED || o_status == ivba_pkg::ST_REJECTED) |-> o_vector_out == 8'h00, "free result carries nonzero vector")
    `IVBA_ASSERT(a_none_vec, o_out_valid && o_status == ivba_pkg::ST_NONE |-> o_vector_out == ivba_pkg::NONE_VECTOR, "exhaustion without all-ones vector")
    `IVBA_ASSERT(a_alloc_unreserved, o_out_valid && o_status == ivba_pkg::ST_ALLOCATED |-> o_vector_out >= 8'(ivba_pkg::RES_BYTES * 8), "reserved vector handed out")

endmodule

bind interrupt_vector_bitmap_allocator_top ivba_checker u_ivba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_op         (i_op),
    .i_vector_in  (i_vector_in),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_vector_out (o_vector_out),
    .o_status     (o_status)
);
